// File: design/fptmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Truncating single-precision multiply / divide package
// Field widths and fixed constants of the single-precision format and of the
// bit-serial multiply and divide sequences.
// ----------------------------------------------------------------------------
package fptmd_pkg;

  localparam int unsigned FracBits = 23;
  localparam int unsigned SigBits  = 24;
  localparam int unsigned ExpBits  = 8;
  localparam int unsigned QuoBits  = 40;

  typedef logic [SigBits-1:0]   sig_t;
  typedef logic [ExpBits-1:0]   exp_t;
  typedef logic [2*SigBits-1:0] prod_t;
  typedef logic [QuoBits-1:0]   quo_t;

  localparam logic OP_MUL = 1'b0;
  localparam logic OP_DIV = 1'b1;

  // Exponent offsets, modulo 256, before the normalization adjustment.
  // Multiply: ea + eb - 127 - 23 + 23 -> ea + eb + 129 (mod 256).
  // Divide:   ea - eb + 127 - 16 + 15 -> ea - eb + 126.
  localparam exp_t MulExpOffset = 8'd129;
  localparam exp_t DivExpOffset = 8'd126;

  localparam logic [5:0] MulLastStep = 6'd23;
  localparam logic [5:0] DivLastStep = 6'd39;

endpackage

// File: design/fp32_truncating_mul_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Truncating single-precision multiply / divide
// Bit-serial product or quotient of two single-precision patterns, truncated.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. A multiply runs one shift-and-add step per
// multiplier bit, and a divide develops a 40-bit quotient by restoring
// division, one quotient bit per cycle; a pack state then normalizes and
// packs the result, which is held until the output beat is taken. The block
// works on one beat at a time: the next input is taken once the result has
// left. Both significands always carry a hidden one, results are truncated,
// and the exponent wraps modulo 256; zero, infinity and NaN patterns get no
// special treatment.
module fp32_truncating_mul_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [31:0] a_bits,
  input  logic [31:0] b_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result_bits
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_PACK = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]          state;
  logic [5:0]          count;
  logic                op;
  logic                sign;
  fptmd_pkg::exp_t     ea;
  fptmd_pkg::exp_t     eb;
  fptmd_pkg::sig_t     sa;
  fptmd_pkg::sig_t     sb;
  fptmd_pkg::prod_t    prod;
  logic [24:0]         rem;
  fptmd_pkg::quo_t     quo;

  // Shift-and-add step: the low product half holds the remaining multiplier.
  logic [24:0]         mul_sum;
  // Restoring-division step.
  logic                div_bit;
  logic [24:0]         div_rem;
  logic                last_step;
  logic [22:0]         pack_frac;
  fptmd_pkg::exp_t     pack_exp;

  assign mul_sum = {1'b0, prod[47:24]} + (prod[0] ? {1'b0, sa} : 25'd0);
  assign div_bit = (rem >= {1'b0, sb});
  assign div_rem = div_bit ? (rem - {1'b0, sb}) : rem;
  assign last_step = (op == fptmd_pkg::OP_MUL) ? (count == fptmd_pkg::MulLastStep)
                                               : (count == fptmd_pkg::DivLastStep);

  // The product lies in [2^46, 2^48) and the quotient in [2^38, 2^40), so the
  // normalizing shift is one of two fixed amounts chosen by the top bit.
  always_comb begin
    if (op == fptmd_pkg::OP_MUL) begin
      pack_frac = prod[47] ? prod[46:24] : prod[45:23];
      pack_exp  = ea + eb + fptmd_pkg::MulExpOffset + {7'd0, prod[47]};
    end else begin
      pack_frac = quo[39] ? quo[38:16] : quo[37:15];
      pack_exp  = ea - eb + fptmd_pkg::DivExpOffset + {7'd0, quo[39]};
    end
  end

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= 6'd0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_RUN;
            count <= 6'd0;
          end
        end
        ST_RUN: begin
          if (last_step) begin
            state <= ST_PACK;
          end
          count <= count + 6'd1;
        end
        ST_PACK: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_stall) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      op   <= operation;
      sign <= a_bits[31] ^ b_bits[31];
      ea   <= a_bits[30:23];
      eb   <= b_bits[30:23];
      sa   <= {1'b1, a_bits[22:0]};
      sb   <= {1'b1, b_bits[22:0]};
      prod <= {24'd0, 1'b1, b_bits[22:0]};
      rem  <= {2'b01, a_bits[22:0]};
      quo  <= '0;
    end else if (state == ST_RUN) begin
      if (op == fptmd_pkg::OP_MUL) begin
        prod <= {mul_sum, prod[23:1]};
      end else begin
        quo <= {quo[38:0], div_bit};
        rem <= {div_rem[23:0], 1'b0};
      end
    end
    if (state == ST_PACK) begin
      result_bits <= {sign, pack_exp, pack_frac};
    end
  end

endmodule

// File: tb/fp32_truncating_mul_div_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Truncating multiply / divide result checker
// Watches both channels, predicts each result word and compares it in order.
// ----------------------------------------------------------------------------
module fp32_truncating_mul_div_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        operation,
  input  logic [31:0] a_bits,
  input  logic [31:0] b_bits,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] result_bits,
  output int          fail_count,
  output int          pending_count
);

  logic [31:0] expected_words[$];

  // Truncated product or quotient of two single-precision patterns.
  function automatic logic [31:0] truncated_result(logic op, logic [31:0] a, logic [31:0] b);
    logic [63:0] sa, sb, sig;
    logic [31:0] ex;
    logic        sgn;
    sgn = a[31] ^ b[31];
    sa = {40'd0, 1'b1, a[22:0]};
    sb = {40'd0, 1'b1, b[22:0]};
    if (op == fptmd_pkg::OP_MUL) begin
      sig = sa * sb;
      ex = 32'(a[30:23]) + 32'(b[30:23]) - 32'd150;
    end else begin
      sig = (sa << 39) / sb;
      ex = 32'(a[30:23]) - 32'(b[30:23]) + 32'd111;
    end
    while (sig > 64'hFFFFFF) begin
      sig = sig >> 1;
      ex = ex + 32'd1;
    end
    while (sig < 64'h800000) begin
      sig = sig << 1;
      ex = ex - 32'd1;
    end
    return {sgn, ex[7:0], sig[22:0]};
  endfunction

  assign pending_count = expected_words.size();

  always @(posedge clk) begin
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall)
        expected_words.push_back(truncated_result(operation, a_bits, b_bits));
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result beat %h", result_bits);
          fail_count <= fail_count + 1;
        end else begin
          if (expected_words[0] !== result_bits) begin
            if (fail_count < 10)
              $display("mismatch: expected %h, got %h", expected_words[0], result_bits);
            fail_count <= fail_count + 1;
          end
          void'(expected_words.pop_front());
        end
      end
    end
  end
endmodule

// File: tb/fp32_truncating_mul_div_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Truncating multiply / divide testbench
// Directed corner operands, then random beats with bursty idling on both sides.
// ----------------------------------------------------------------------------
module fp32_truncating_mul_div_tb;

  localparam int RandomBeats = 1330;
  localparam int WatchdogLimit = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic operation = fptmd_pkg::OP_MUL;
  logic [31:0] a_bits = '0;
  logic [31:0] b_bits = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] result_bits;
  int fail_count, pending_count;
  int idle_cycles;
  bit quiet_tail = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  fp32_truncating_mul_div DUT (.*);

  fp32_truncating_mul_div_checker u_checker (.*);

  // The watchdog counts cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("[fp32_truncating_mul_div] ERROR");
      $finish;
    end
  end

  // The receiver stalls in random bursts until the quiet tail of the run.
  initial begin
    int n;
    @(posedge clk iff !rst);
    while (!quiet_tail) begin
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 17);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
    out_stall <= 1'b0;
  end

  // Presents one beat and holds it until the block takes it.
  task automatic send_beat(logic op, logic [31:0] a, logic [31:0] b);
    in_valid <= 1'b1;
    operation <= op;
    a_bits <= a;
    b_bits <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Random operand: uniform half the time, else with an extreme exponent or fraction.
  function automatic logic [31:0] random_operand();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 7))
      0: v[30:23] = 8'h00;
      1: v[30:23] = 8'hFF;
      2: v[22:0] = '0;
      3: v[22:0] = '1;
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    logic [31:0] corners[8];
    corners = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7F80_0000, 32'h8000_0000,
                32'h3F80_0000, 32'h007F_FFFF, 32'h7FFF_FFFF, 32'hBF7F_FFFF};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: corner operands against each other for both operations.
    for (int i = 0; i < 8; i++) begin
      send_beat(fptmd_pkg::OP_MUL, corners[i], corners[7 - i]);
      send_beat(fptmd_pkg::OP_DIV, corners[i], corners[(i + 3) % 8]);
    end
    send_beat(fptmd_pkg::OP_DIV, 32'h3F80_0000, 32'h3F80_0000);
    send_beat(fptmd_pkg::OP_DIV, 32'h3F80_0000, 32'h3FFF_FFFF);
    send_beat(fptmd_pkg::OP_MUL, 32'h3FFF_FFFF, 32'h3FFF_FFFF);
    in_valid <= 1'b0;

    // Hold off until every expected result has arrived.
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);

    for (int i = 0; i < RandomBeats; i++) begin
      if (i == RandomBeats - 150) quiet_tail = 1'b1;
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      send_beat(1'($urandom_range(0, 1)), random_operand(), random_operand());
    end
    in_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("[fp32_truncating_mul_div] OK");
    else
      $display("[fp32_truncating_mul_div] ERROR");
    $finish;
  end
endmodule

// File: filelist.f
design/fptmd_pkg.sv
design/fp32_truncating_mul_div.sv
tb/fp32_truncating_mul_div_checker.sv
tb/fp32_truncating_mul_div_tb.sv
